// ----- rtl/core/pfx_pkg.sv -----
package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_BADSYM  = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } alu_op_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_POW,
        A_DIV,
        A_DIV_END,
        A_DONE
    } alu_state_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_DECODE,
        T_RD_RHS,
        T_RD_LHS,
        T_EXEC,
        T_WAIT,
        T_FIN_RD,
        T_FIN_CAP
    } top_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

// ----- rtl/core/pfx_alu.sv -----
module pfx_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfx_pkg::alu_req_t              req,
    input  logic [pfx_pkg::DATA_W-1:0]     a,
    input  logic [pfx_pkg::DATA_W-1:0]     b,
    output pfx_pkg::alu_rsp_t              rsp
);
    import pfx_pkg::*;

    alu_state_t          state_reg, state_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic [DATA_W-1:0]   m_acc_reg, m_acc_next;
    logic [DATA_W-1:0]   m_cand_reg, m_cand_next;
    logic [DATA_W-1:0]   m_plier_reg, m_plier_next;
    logic                pow_mode_reg, pow_mode_next;
    logic                p_tgt_reg, p_tgt_next;
    logic                p_phase_reg, p_phase_next;
    logic [DATA_W-1:0]   p_acc_reg, p_acc_next;
    logic [DATA_W-1:0]   p_sq_reg, p_sq_next;
    logic [DATA_W-1:0]   p_e_reg, p_e_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DATA_W-1:0]   a_mag, b_mag;
    logic [DATA_W:0]     shift_rem, trial;

    assign a_mag     = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
    assign b_mag     = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
    assign shift_rem = {rem_reg, quo_reg[DATA_W-1]};
    assign trial     = shift_rem - {1'b0, dvs_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_MUL:  state_next = A_MUL;
                        OP_DIV:  state_next = A_DIV;
                        OP_POW:  state_next = b[DATA_W-1] ? A_DONE : A_POW;
                        default: state_next = A_DONE;
                    endcase
                end
            end
            A_MUL:
            begin
                if (m_plier_reg == '0)
                    state_next = pow_mode_reg ? A_POW : A_DONE;
            end
            A_POW:
            begin
                if (p_e_reg == '0)
                    state_next = A_DONE;
                else if (!p_phase_reg && p_e_reg[0])
                    state_next = A_MUL;
                else if (p_phase_reg && (p_e_reg[DATA_W-1:1] != '0))
                    state_next = A_MUL;
            end
            A_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                    state_next = A_DIV_END;
            end
            A_DIV_END: state_next = A_DONE;
            A_DONE:    state_next = A_IDLE;
            default:   state_next = A_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        res_next      = res_reg;
        m_acc_next    = m_acc_reg;
        m_cand_next   = m_cand_reg;
        m_plier_next  = m_plier_reg;
        pow_mode_next = pow_mode_reg;
        p_tgt_next    = p_tgt_reg;
        p_phase_next  = p_phase_reg;
        p_acc_next    = p_acc_reg;
        p_sq_next     = p_sq_reg;
        p_e_next      = p_e_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_ADD: res_next = a + b;
                        OP_SUB: res_next = a - b;
                        OP_MUL:
                        begin
                            m_acc_next    = '0;
                            m_cand_next   = a;
                            m_plier_next  = b;
                            pow_mode_next = 1'b0;
                        end
                        OP_DIV:
                        begin
                            rem_next = '0;
                            quo_next = a_mag;
                            dvs_next = b_mag;
                            neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                            cnt_next = '0;
                        end
                        OP_POW:
                        begin
                            // negative exponent: only unit bases survive
                            if (a == DATA_W'(1))
                                res_next = DATA_W'(1);
                            else if (a == '1)
                                res_next = b[0] ? '1 : DATA_W'(1);
                            else
                                res_next = '0;
                            p_acc_next    = DATA_W'(1);
                            p_sq_next     = a;
                            p_e_next      = b;
                            p_phase_next  = 1'b0;
                            pow_mode_next = 1'b1;
                        end
                        default: res_next = res_reg;
                    endcase
                end
            end
            A_MUL:
            begin
                if (m_plier_reg == '0)
                begin
                    res_next = m_acc_reg;
                    if (pow_mode_reg)
                    begin
                        if (p_tgt_reg)
                            p_sq_next = m_acc_reg;
                        else
                            p_acc_next = m_acc_reg;
                    end
                end
                else
                begin
                    if (m_plier_reg[0])
                        m_acc_next = m_acc_reg + m_cand_reg;
                    m_cand_next  = {m_cand_reg[DATA_W-2:0], 1'b0};
                    m_plier_next = {1'b0, m_plier_reg[DATA_W-1:1]};
                end
            end
            A_POW:
            begin
                if (p_e_reg == '0)
                    res_next = p_acc_reg;
                else if (!p_phase_reg)
                begin
                    p_phase_next = 1'b1;
                    if (p_e_reg[0])
                    begin
                        m_acc_next   = '0;
                        m_cand_next  = p_acc_reg;
                        m_plier_next = p_sq_reg;
                        p_tgt_next   = 1'b0;
                    end
                end
                else
                begin
                    p_phase_next = 1'b0;
                    p_e_next     = {1'b0, p_e_reg[DATA_W-1:1]};
                    m_acc_next   = '0;
                    m_cand_next  = p_sq_reg;
                    m_plier_next = p_sq_reg;
                    p_tgt_next   = 1'b1;
                end
            end
            A_DIV:
            begin
                if (!trial[DATA_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shift_rem[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
            A_DIV_END:
            begin
                res_next = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;
            end
            default: res_next = res_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        rsp.done   = (state_reg == A_DONE);
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        m_acc_reg    <= m_acc_next;
        m_cand_reg   <= m_cand_next;
        m_plier_reg  <= m_plier_next;
        pow_mode_reg <= pow_mode_next;
        p_tgt_reg    <= p_tgt_next;
        p_phase_reg  <= p_phase_next;
        p_acc_reg    <= p_acc_next;
        p_sq_reg     <= p_sq_next;
        p_e_reg      <= p_e_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        neg_reg      <= neg_next;
    end

endmodule

// ----- rtl/core/postfix_expression_evaluator_unit.sv -----
// Postfix evaluator: one ASCII character per item; digits push 0..9, + - * / ^ pop
// two operands and push the 32-bit wrapped result; the item with last set returns
// the top value and a status (0 ok, 1 underflow, 2 overflow, 3 divide by zero,
// 4 bad symbol, 5 empty), after which the stack and error clear. One item is in
// flight at a time. * shifts and adds once per significant bit of the right operand,
// / runs a restoring divide over all DATA_W quotient bits, and ^ runs one or two passes
// of the shared shift-add multiplier inside the ALU for every exponent bit. The last
// item then reads the top of the stack. Operands sit in a one-read, one-write stack
// memory of STACK_DEPTH words with a registered read port.
module postfix_expression_evaluator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [7:0]                    symbol,
    input  logic                          last,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic signed [pfx_pkg::DATA_W-1:0] value,
    output logic [2:0]                    status
);
    import pfx_pkg::*;

    top_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    status_t             err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    status_t             status_reg, status_next;
    logic [7:0]          sym_reg;
    logic                last_reg;
    logic [DATA_W-1:0]   rhs_reg, rhs_next;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                wr_en;

    logic [CNT_W-1:0]    cnt_m1, cnt_m2;
    logic                is_digit, is_op, stack_full, too_few, out_free, accept;
    alu_op_t             op_code;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    assign accept     = req_valid && !req_stall;
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign cnt_m2     = cnt_reg - CNT_W'(2);
    assign is_digit   = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
    assign stack_full = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign too_few    = (cnt_reg < CNT_W'(2));
    assign out_free   = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        is_op   = 1'b1;
        op_code = OP_ADD;
        case (sym_reg)
            CH_PLUS:  op_code = OP_ADD;
            CH_MINUS: op_code = OP_SUB;
            CH_STAR:  op_code = OP_MUL;
            CH_SLASH: op_code = OP_DIV;
            CH_CARET: op_code = OP_POW;
            default:  is_op = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                    state_next = T_DECODE;
            end
            T_DECODE:
            begin
                if (err_reg == ST_OK && !is_digit && is_op && !too_few)
                    state_next = T_RD_RHS;
                else
                    state_next = last_reg ? T_FIN_RD : T_IDLE;
            end
            T_RD_RHS: state_next = T_RD_LHS;
            T_RD_LHS: state_next = T_EXEC;
            T_EXEC:
            begin
                if (op_code == OP_DIV && rhs_reg == '0)
                    state_next = last_reg ? T_FIN_RD : T_IDLE;
                else
                    state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (alu_rsp.done)
                    state_next = last_reg ? T_FIN_RD : T_IDLE;
            end
            T_FIN_RD: state_next = T_FIN_CAP;
            T_FIN_CAP:
            begin
                if (out_free)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        rhs_next       = rhs_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[ADDR_W-1:0];
        wr_data        = DATA_W'(sym_reg - CH_ZERO);
        rd_addr        = (state_reg == T_RD_LHS) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
        alu_req.start  = 1'b0;
        alu_req.op     = op_code;
        case (state_reg)
            T_DECODE:
            begin
                if (err_reg == ST_OK)
                begin
                    if (is_digit)
                    begin
                        if (stack_full)
                            err_next = ST_OVER;
                        else
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (!is_op)
                        err_next = ST_BADSYM;
                    else if (too_few)
                        err_next = ST_UNDER;
                end
            end
            T_RD_LHS: rhs_next = rd_data_reg;
            T_EXEC:
            begin
                if (op_code == OP_DIV && rhs_reg == '0)
                    err_next = ST_DIVZERO;
                else
                    alu_req.start = 1'b1;
            end
            T_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cnt_m2[ADDR_W-1:0];
                    wr_data  = alu_rsp.result;
                    cnt_next = cnt_m1;
                end
            end
            T_FIN_CAP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        value_next  = '0;
                        status_next = err_reg;
                    end
                    else if (cnt_reg == '0)
                    begin
                        value_next  = '0;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        value_next  = rd_data_reg;
                        status_next = ST_OK;
                    end
                    cnt_next = '0;
                    err_next = ST_OK;
                end
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    pfx_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rd_data_reg),
        .b     (rhs_reg),
        .rsp   (alu_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
        end
        rhs_reg    <= rhs_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign req_stall = (state_reg != T_IDLE);
    assign rsp_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_FIN_CAP) && out_free |=> rsp_valid && (cnt_reg == '0)
            && (err_reg == ST_OK))
        else $error("result not loaded or stack not cleared");

    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == T_WAIT))
        else $error("ALU finished outside wait state");
`endif

endmodule
